// File: sv/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

    // Fixed field widths
    localparam int OPCODE_W   = 3;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 18;
    localparam int BASE_W     = 29;
    localparam int FRAMES_W   = 18;
    localparam int KB_W       = 22;
    localparam int KFRAME_W   = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 72;

    // Defaults for the top-level parameters
    localparam int MAX_FRAMES_DEF   = 131072;
    localparam int WORD_BITS_DEF    = 32;
    localparam int FRAME_BYTES_DEF  = 4096;
    localparam int RESERVED_LOW_DEF = 256;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_INIT      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC_ONE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FREE_ONE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ALLOC_RUN = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FREE_RUN  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_KB    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INIT_WR,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_FIND_BIT,
        ST_RMW_SEEK,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_SETTLE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic init_wr;
        logic mem_rd;
        logic word_inc;
        logic word_seek;
        logic run_clr;
        logic run_add_word;
        logic run_inc;
        logic bit_clr;
        logic bit_inc;
        logic range_one;
        logic range_word;
        logic range_bit;
        logic rmw_wr;
        logic used_add;
        logic ok_set;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic total_zero;
        logic alloc_bad;
        logic range_empty;
        logic init_last;
        logic word_last;
        logic has_zero;
        logic all_zero;
        logic all_one;
        logic run_fits_word;
        logic bit_free;
        logic run_hits;
        logic bit_last;
        logic rmw_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: sv/bfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bfa_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire bfa_pkg::status_t status,
    output bfa_pkg::cmd_t         cmd
);

    bfa_pkg::state_t state_reg;
    bfa_pkg::state_t state_next;

    logic is_alloc;
    assign is_alloc = (status.op == bfa_pkg::OP_ALLOC_ONE) ||
                      (status.op == bfa_pkg::OP_ALLOC_RUN);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfa_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = bfa_pkg::ST_DISPATCH;
            end
            bfa_pkg::ST_DISPATCH: begin
                case (status.op)
                    bfa_pkg::OP_INIT: state_next = bfa_pkg::ST_INIT_WR;
                    bfa_pkg::OP_ALLOC_ONE: begin
                        state_next = status.total_zero ? bfa_pkg::ST_SETTLE
                                                       : bfa_pkg::ST_FIND_RD;
                    end
                    bfa_pkg::OP_ALLOC_RUN: begin
                        state_next = status.alloc_bad ? bfa_pkg::ST_SETTLE
                                                      : bfa_pkg::ST_FIND_RD;
                    end
                    bfa_pkg::OP_FREE_ONE, bfa_pkg::OP_FREE_RUN: begin
                        state_next = status.range_empty ? bfa_pkg::ST_SETTLE
                                                        : bfa_pkg::ST_RMW_SEEK;
                    end
                    default: state_next = bfa_pkg::ST_SETTLE;
                endcase
            end
            bfa_pkg::ST_INIT_WR: begin
                if (status.init_last) state_next = bfa_pkg::ST_SETTLE;
            end
            bfa_pkg::ST_FIND_RD: state_next = bfa_pkg::ST_FIND_CHK;
            bfa_pkg::ST_FIND_CHK: begin
                if (status.op == bfa_pkg::OP_ALLOC_ONE) begin
                    if (status.has_zero) state_next = bfa_pkg::ST_RMW_RD;
                    else if (status.word_last) state_next = bfa_pkg::ST_SETTLE;
                    else state_next = bfa_pkg::ST_FIND_RD;
                end else if (status.all_zero && status.run_fits_word) begin
                    state_next = bfa_pkg::ST_RMW_SEEK;
                end else if (status.all_zero || status.all_one) begin
                    state_next = status.word_last ? bfa_pkg::ST_SETTLE
                                                  : bfa_pkg::ST_FIND_RD;
                end else begin
                    state_next = bfa_pkg::ST_FIND_BIT;
                end
            end
            bfa_pkg::ST_FIND_BIT: begin
                if (status.bit_free && status.run_hits) begin
                    state_next = bfa_pkg::ST_RMW_SEEK;
                end else if (status.bit_last) begin
                    state_next = status.word_last ? bfa_pkg::ST_SETTLE
                                                  : bfa_pkg::ST_FIND_RD;
                end
            end
            bfa_pkg::ST_RMW_SEEK: state_next = bfa_pkg::ST_RMW_RD;
            bfa_pkg::ST_RMW_RD:   state_next = bfa_pkg::ST_RMW_WR;
            bfa_pkg::ST_RMW_WR: begin
                state_next = status.rmw_last ? bfa_pkg::ST_SETTLE
                                             : bfa_pkg::ST_RMW_RD;
            end
            bfa_pkg::ST_SETTLE: state_next = bfa_pkg::ST_DONE;
            bfa_pkg::ST_DONE: begin
                if (status.out_free) state_next = bfa_pkg::ST_IDLE;
            end
            default: state_next = bfa_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            bfa_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            bfa_pkg::ST_DISPATCH: begin
                if (((status.op == bfa_pkg::OP_FREE_ONE) ||
                     (status.op == bfa_pkg::OP_FREE_RUN)) && status.range_empty) begin
                    cmd.ok_set = 1'b1;
                end
            end
            bfa_pkg::ST_INIT_WR: begin
                cmd.init_wr  = 1'b1;
                cmd.word_inc = !status.init_last;
                cmd.ok_set   = status.init_last;
            end
            bfa_pkg::ST_FIND_RD: cmd.mem_rd = 1'b1;
            bfa_pkg::ST_FIND_CHK: begin
                if (status.op == bfa_pkg::OP_ALLOC_ONE) begin
                    if (status.has_zero) cmd.range_one = 1'b1;
                    else cmd.word_inc = !status.word_last;
                end else if (status.all_zero && status.run_fits_word) begin
                    cmd.range_word = 1'b1;
                end else if (status.all_zero) begin
                    cmd.run_add_word = 1'b1;
                    cmd.word_inc     = !status.word_last;
                end else if (status.all_one) begin
                    cmd.run_clr  = 1'b1;
                    cmd.word_inc = !status.word_last;
                end else begin
                    cmd.bit_clr = 1'b1;
                end
            end
            bfa_pkg::ST_FIND_BIT: begin
                if (status.bit_free && status.run_hits) begin
                    cmd.range_bit = 1'b1;
                end else begin
                    cmd.run_inc  = status.bit_free;
                    cmd.run_clr  = !status.bit_free;
                    cmd.bit_inc  = !status.bit_last;
                    cmd.word_inc = status.bit_last && !status.word_last;
                end
            end
            bfa_pkg::ST_RMW_SEEK: cmd.word_seek = 1'b1;
            bfa_pkg::ST_RMW_RD:   cmd.mem_rd = 1'b1;
            bfa_pkg::ST_RMW_WR: begin
                cmd.rmw_wr   = 1'b1;
                cmd.word_inc = !status.rmw_last;
                cmd.ok_set   = status.rmw_last;
                cmd.used_add = status.rmw_last && is_alloc;
            end
            bfa_pkg::ST_SETTLE: ;
            bfa_pkg::ST_DONE: cmd.emit = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/bfa_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module bfa_dpath #(
    parameter int MAX_FRAMES   = bfa_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS    = bfa_pkg::WORD_BITS_DEF,
    parameter int FRAME_BYTES  = bfa_pkg::FRAME_BYTES_DEF,
    parameter int RESERVED_LOW = bfa_pkg::RESERVED_LOW_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request fields
    input  wire logic [bfa_pkg::OPCODE_W-1:0]      in_opcode,
    input  wire logic [bfa_pkg::ADDR_W-1:0]        in_address,
    input  wire logic [bfa_pkg::COUNT_W-1:0]       in_count,
    // result register
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bfa_pkg::M_TDATA_W-1:0]          m_tdata,
    // controller link
    input  wire bfa_pkg::cmd_t                     cmd,
    output bfa_pkg::status_t                       status
);

    localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = $clog2(NWORDS);
    localparam int BWL    = $clog2(WORD_BITS);
    localparam int FBL    = $clog2(FRAME_BYTES);
    localparam int CW     = $clog2(MAX_FRAMES + 1);
    localparam int FW_A   = bfa_pkg::ADDR_W + 2 - FBL;
    localparam int FW_B   = (CW + 1 > bfa_pkg::KFRAME_W + 1) ? CW + 1 : bfa_pkg::KFRAME_W + 1;
    localparam int FW     = (FW_A > FW_B) ? FW_A : FW_B;
    localparam int RW     = bfa_pkg::COUNT_W + 1;

    // Bitmap memory, one bit per frame, set means used
    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [bfa_pkg::KB_W-1:0]     mem_kb_reg;
    logic [bfa_pkg::KFRAME_W-1:0] kfirst_reg;
    logic [bfa_pkg::KFRAME_W-1:0] kend_reg;
    logic [bfa_pkg::OPCODE_W-1:0] op_reg;
    logic [bfa_pkg::COUNT_W-1:0]  cnt_reg;
    logic [CW-1:0]                total_reg;
    logic [CW-1:0]                used_reg;
    logic [CW-1:0]                used_next;
    logic [AW-1:0]                word_reg;
    logic [BWL-1:0]               bit_reg;
    logic [bfa_pkg::COUNT_W-1:0]  run_reg;
    logic [FW-1:0]                lo_reg;
    logic [FW-1:0]                hi_reg;
    logic [BWL:0]                 pop_reg;
    logic                         ok_reg;
    logic [bfa_pkg::BASE_W-1:0]   base_reg;
    logic                         m_valid_reg;
    logic [bfa_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [FW-1:0]        tot_fw;
    logic [FW-1:0]        kend_min;
    logic [FW-1:0]        word_base;
    logic [FW-1:0]        fr [WORD_BITS];
    logic [WORD_BITS-1:0] init_word;
    logic [WORD_BITS-1:0] below_total;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] wr_word;
    logic [BWL-1:0]       zidx;
    logic [FW-1:0]        first_in;
    logic [FW-1:0]        end_in;
    logic [31:0]          frames_raw;
    logic [CW-1:0]        total_new;
    logic [CW-1:0]        tot_m1;
    logic [FW-1:0]        hi_m1;
    logic [FW-1:0]        hi_word;
    logic [FW-1:0]        hi_bit;
    logic [FW+FBL-1:0]    base_full;
    logic                 op_is_alloc;

    assign cfg_ready   = 1'b1;
    assign tot_fw      = FW'(total_reg);
    assign kend_min    = (FW'(kend_reg) < FW'(MAX_FRAMES)) ? FW'(kend_reg) : FW'(MAX_FRAMES);
    assign word_base   = FW'({word_reg, {BWL{1'b0}}});
    assign op_is_alloc = (op_reg == bfa_pkg::OP_ALLOC_ONE) || (op_reg == bfa_pkg::OP_ALLOC_RUN);

    // Per-bit frame numbers and masks for the current word
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            fr[i]          = word_base + FW'(i);
            init_word[i]   = (fr[i] >= tot_fw) || (fr[i] == '0) ||
                             (fr[i] < FW'(RESERVED_LOW)) ||
                             ((fr[i] >= FW'(kfirst_reg)) && (fr[i] < kend_min));
            below_total[i] = fr[i] < tot_fw;
            range_mask[i]  = (fr[i] >= lo_reg) && (fr[i] < hi_reg);
        end
    end

    // Lowest free bit of the word just read
    always_comb begin
        zidx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rd_data_reg[i]) zidx = BWL'(i);
        end
    end

    // Word written back: init pattern, or set/clear the range
    always_comb begin
        if (cmd.init_wr) wr_word = init_word;
        else if (op_is_alloc) wr_word = rd_data_reg | range_mask;
        else wr_word = rd_data_reg & ~range_mask;
    end

    // Request decode
    assign first_in   = FW'(in_address >> FBL);
    assign end_in     = first_in + ((in_opcode == bfa_pkg::OP_FREE_ONE) ? FW'(1) : FW'(in_count));
    assign frames_raw = {mem_kb_reg, 10'b0} >> FBL;
    assign total_new  = (frames_raw > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(frames_raw);
    assign tot_m1     = total_reg - CW'(1);
    assign hi_m1      = hi_reg - FW'(1);
    assign hi_word    = word_base + FW'(cnt_reg) - FW'(run_reg);
    assign hi_bit     = word_base + FW'(bit_reg) + FW'(1);
    assign base_full  = {lo_reg, {FBL{1'b0}}};

    // Status for the controller
    always_comb begin
        status.op            = op_reg;
        status.total_zero    = total_reg == '0;
        status.alloc_bad     = (cnt_reg == '0) || (FW'(cnt_reg) > tot_fw);
        status.range_empty   = lo_reg >= hi_reg;
        status.init_last     = word_reg == AW'(NWORDS - 1);
        status.word_last     = word_reg == AW'(tot_m1 >> BWL);
        status.has_zero      = !(&rd_data_reg);
        status.all_zero      = rd_data_reg == '0;
        status.all_one       = &rd_data_reg;
        status.run_fits_word = (RW'(run_reg) + RW'(WORD_BITS)) >= RW'(cnt_reg);
        status.bit_free      = !rd_data_reg[bit_reg];
        status.run_hits      = (RW'(run_reg) + RW'(1)) == RW'(cnt_reg);
        status.bit_last      = bit_reg == BWL'(WORD_BITS - 1);
        status.rmw_last      = word_reg == AW'(hi_m1 >> BWL);
        status.out_free      = !m_valid_reg || m_tready;
    end

    // Memory port: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.init_wr || cmd.rmw_wr) mem[word_reg] <= wr_word;
        if (cmd.mem_rd) rd_data_reg <= mem[word_reg];
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_kb_reg <= '0;
            kfirst_reg <= '0;
            kend_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bfa_pkg::REG_MEMORY_KB:    mem_kb_reg <= cfg_data;
                bfa_pkg::REG_KERNEL_FIRST: kfirst_reg <= cfg_data[bfa_pkg::KFRAME_W-1:0];
                bfa_pkg::REG_KERNEL_END:   kend_reg   <= cfg_data[bfa_pkg::KFRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Used count: pending popcount lands in the cycle after its write
    always_comb begin
        used_next = used_reg;
        if (op_reg == bfa_pkg::OP_INIT) used_next = used_next + CW'(pop_reg);
        else used_next = used_next - CW'(pop_reg);
        if (cmd.used_add) used_next = used_next + CW'(cnt_reg);
    end

    // Counters and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            used_reg  <= '0;
            pop_reg   <= '0;
            op_reg    <= bfa_pkg::OP_INIT;
        end else begin
            if (cmd.init_wr) pop_reg <= (BWL+1)'($countones(init_word & below_total));
            else if (cmd.rmw_wr && !op_is_alloc)
                pop_reg <= (BWL+1)'($countones(rd_data_reg & range_mask));
            else pop_reg <= '0;

            if (cmd.accept) begin
                op_reg <= in_opcode;
                if (in_opcode == bfa_pkg::OP_INIT) begin
                    total_reg <= total_new;
                    used_reg  <= '0;
                end
            end else begin
                used_reg <= used_next;
            end
        end
    end

    // Search and range registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cnt_reg  <= (in_opcode == bfa_pkg::OP_ALLOC_ONE ||
                         in_opcode == bfa_pkg::OP_FREE_ONE) ? bfa_pkg::COUNT_W'(1) : in_count;
            word_reg <= '0;
            run_reg  <= '0;
            bit_reg  <= '0;
            lo_reg   <= first_in;
            hi_reg   <= (end_in < tot_fw) ? end_in : tot_fw;
        end else begin
            if (cmd.word_seek) word_reg <= AW'(lo_reg >> BWL);
            else if (cmd.word_inc) word_reg <= word_reg + AW'(1);

            if (cmd.run_clr) run_reg <= '0;
            else if (cmd.run_add_word) run_reg <= run_reg + bfa_pkg::COUNT_W'(WORD_BITS);
            else if (cmd.run_inc) run_reg <= run_reg + bfa_pkg::COUNT_W'(1);

            if (cmd.bit_clr) bit_reg <= '0;
            else if (cmd.bit_inc) bit_reg <= bit_reg + BWL'(1);

            if (cmd.range_one) begin
                lo_reg <= word_base + FW'(zidx);
                hi_reg <= word_base + FW'(zidx) + FW'(1);
            end else if (cmd.range_word) begin
                lo_reg <= hi_word - FW'(cnt_reg);
                hi_reg <= hi_word;
            end else if (cmd.range_bit) begin
                lo_reg <= hi_bit - FW'(cnt_reg);
                hi_reg <= hi_bit;
            end
        end
    end

    // Result fields
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ok_reg   <= 1'b0;
            base_reg <= '0;
        end else if (cmd.ok_set) begin
            ok_reg   <= 1'b1;
            base_reg <= op_is_alloc ? bfa_pkg::BASE_W'(base_full) : '0;
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_data_reg <= {6'b0,
                           bfa_pkg::FRAMES_W'(total_reg),
                           bfa_pkg::FRAMES_W'(total_reg - used_reg),
                           base_reg, ok_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Marked frames never outnumber managed frames
    assert property (@(posedge aclk) disable iff (!aresetn) used_reg <= total_reg)
        else $error("used count above frame total");

    // A range update always covers at least one frame
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.rmw_wr |-> (lo_reg < hi_reg))
        else $error("empty range written");

    // A result is loaded only when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("result overwritten");

    // An allocation that succeeds never hands out frames past the total
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.used_add) |-> (hi_reg <= tot_fw))
        else $error("allocation past frame total");

endmodule

`default_nettype wire

// File: sv/bitmap_frame_allocator_unit.sv
// Bitmap frame allocator, first fit, one used bit per frame.
// Requests arrive on the s_ stream: opcode, byte address and frame count.
// Each request gives exactly one result on the m_ stream: ok, base address,
// free frame count and total frame count. A separate cfg_ write channel sets
// installed memory and the kernel frame range; these are sampled by init.
// One request is in work at a time; s_tready is high only while idle, and a
// new request is taken while the previous result still waits in the output
// register. The work per request:
//   init          writes every bitmap word, one bitmap word written per cycle
//   alloc one     reads words until one holds a free frame, then marks it
//   alloc run     reads words, steps bit by bit through partly used words,
//                 then marks each word of the run that it found
//   free one/run  reads and rewrites each word that the range touches
// The bitmap memory has one port, so the scans and updates go a word at a
// time. After reset the total is zero: every allocation fails and every
// free is ignored until an init fills the bitmap; no clearing pass runs.
// A stalled receiver holds the result register, and the next result waits
// in its final state until that register empties.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_frame_allocator_unit #(
    parameter int MAX_FRAMES   = bfa_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS    = bfa_pkg::WORD_BITS_DEF,
    parameter int FRAME_BYTES  = bfa_pkg::FRAME_BYTES_DEF,
    parameter int RESERVED_LOW = bfa_pkg::RESERVED_LOW_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bfa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // opcode[2:0], address[34:3], count[52:35], zero fill
    input  wire logic [bfa_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // ok[0], base_address[29:1], free_frames[47:30], total_frames[65:48], zero fill
    output logic [bfa_pkg::M_TDATA_W-1:0]       m_tdata
);

    bfa_pkg::cmd_t    cmd;
    bfa_pkg::status_t status;

    bfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bfa_dpath #(
        .MAX_FRAMES   (MAX_FRAMES),
        .WORD_BITS    (WORD_BITS),
        .FRAME_BYTES  (FRAME_BYTES),
        .RESERVED_LOW (RESERVED_LOW)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_opcode  (s_tdata[2:0]),
        .in_address (s_tdata[34:3]),
        .in_count   (s_tdata[52:35]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

`default_nettype wire

// File: verif/tb_bitmap_frame_allocator_unit.sv
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator_unit;
    import bfa_pkg::*;

    localparam int NFRAMES   = MAX_FRAMES_DEF;
    localparam int FBYTES    = FRAME_BYTES_DEF;
    localparam int RSV_LOW   = RESERVED_LOW_DEF;
    localparam int CYCLE_CAP = 20000000;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [ADDR_W-1:0]   address;
        logic [COUNT_W-1:0]  count;
    } frame_req_t;

    typedef struct {
        logic                ok;
        logic [BASE_W-1:0]   base_address;
        logic [FRAMES_W-1:0] free_frames;
        logic [FRAMES_W-1:0] total_cnt;
    } frame_resp_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    bitmap_frame_allocator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Shadow allocator state
    bit          frame_used [NFRAMES];
    int unsigned shadow_total = 0;
    int unsigned shadow_used  = 0;
    int unsigned shadow_kb    = 0;
    int unsigned shadow_kfirst = 0;
    int unsigned shadow_kend  = 0;

    frame_req_t  pending_reqs [$];
    frame_resp_t expected_resps [$];
    frame_req_t  driven_req;
    int unsigned mismatches = 0;
    longint      cycle_count = 0;

    // Release one frame if it is managed and marked
    function automatic void release_frame(longint unsigned f);
        if (f < shadow_total && frame_used[f]) begin
            frame_used[f] = 1'b0;
            shadow_used--;
        end
    endfunction

    function automatic void run_init();
        int unsigned stop;
        shadow_total = shadow_kb / (FBYTES / 1024);
        if (shadow_total > NFRAMES) shadow_total = NFRAMES;
        for (int f = 0; f < NFRAMES; f++) frame_used[f] = (f >= shadow_total);
        frame_used[0] = 1'b1;
        stop = (shadow_kend < NFRAMES) ? shadow_kend : NFRAMES;
        for (int unsigned f = shadow_kfirst; f < stop; f++) frame_used[f] = 1'b1;
        for (int f = 0; f < RSV_LOW && f < NFRAMES; f++) frame_used[f] = 1'b1;
        shadow_used = 0;
        for (int unsigned f = 0; f < shadow_total; f++)
            if (frame_used[f]) shadow_used++;
    endfunction

    // Compute the result of one request and advance the shadow state
    function automatic frame_resp_t predict_alloc(frame_req_t r);
        frame_resp_t     res;
        longint unsigned base;
        longint unsigned first;
        int unsigned     run;
        int unsigned     cnt;
        res.ok = 1'b0;
        base = 0;
        cnt = r.count;
        case (r.opcode)
            OP_INIT: begin
                run_init();
                res.ok = 1'b1;
            end
            OP_ALLOC_ONE: begin
                for (int unsigned f = 0; f < shadow_total; f++) begin
                    if (!frame_used[f]) begin
                        frame_used[f] = 1'b1;
                        shadow_used++;
                        res.ok = 1'b1;
                        base = longint'(f) * FBYTES;
                        break;
                    end
                end
            end
            OP_FREE_ONE: begin
                release_frame(r.address / FBYTES);
                res.ok = 1'b1;
            end
            OP_ALLOC_RUN: begin
                if (cnt != 0 && cnt <= shadow_total) begin
                    run = 0;
                    for (int unsigned f = 0; f < shadow_total; f++) begin
                        if (frame_used[f]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == cnt) begin
                                for (int unsigned g = f + 1 - cnt; g <= f; g++)
                                    frame_used[g] = 1'b1;
                                shadow_used += cnt;
                                res.ok = 1'b1;
                                base = longint'(f + 1 - cnt) * FBYTES;
                                break;
                            end
                        end
                    end
                end
            end
            OP_FREE_RUN: begin
                first = r.address / FBYTES;
                for (longint unsigned k = 0; k < cnt; k++) begin
                    if (first + k >= shadow_total) break;
                    release_frame(first + k);
                end
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.base_address = base[BASE_W-1:0];
        res.free_frames  = FRAMES_W'(shadow_total - shadow_used);
        res.total_cnt    = FRAMES_W'(shadow_total);
        return res;
    endfunction

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // Request driver
    int  send_gap   = 0;
    bit  send_burst = 0;
    logic next_valid;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_resps.push_back(predict_alloc(driven_req));
            if ($urandom_range(0, 149) == 0) send_burst = ~send_burst;
            if (s_tvalid && !s_tready) begin
                next_valid = 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                next_valid = 1'b0;
            end else if (pending_reqs.size() != 0) begin
                driven_req = pending_reqs.pop_front();
                s_tdata <= {3'b000, driven_req.count, driven_req.address, driven_req.opcode};
                next_valid = 1'b1;
                send_gap = send_burst ? 0 : pick_gap();
            end else begin
                next_valid = 1'b0;
            end
            s_tvalid <= next_valid;
        end
    end

    // Result monitor and receiver stalls
    int  recv_gap   = 0;
    bit  recv_burst = 0;
    frame_resp_t want;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_resps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %h", m_tdata);
                end else begin
                    want = expected_resps.pop_front();
                    if (m_tdata[0] !== want.ok || m_tdata[29:1] !== want.base_address ||
                        m_tdata[47:30] !== want.free_frames ||
                        m_tdata[65:48] !== want.total_cnt) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp ok=%0d base=%h free=%0d total=%0d",
                                     want.ok, want.base_address, want.free_frames,
                                     want.total_cnt);
                            $display("          got ok=%0d base=%h free=%0d total=%0d",
                                     m_tdata[0], m_tdata[29:1],
                                     m_tdata[47:30], m_tdata[65:48]);
                        end
                    end
                end
            end
            if ($urandom_range(0, 149) == 0) recv_burst = ~recv_burst;
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = recv_burst ? 0 : pick_gap();
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MEMORY_KB:    shadow_kb     = val & 32'h3F_FFFF;
            REG_KERNEL_FIRST: shadow_kfirst = val & 32'h1F_FFFF;
            REG_KERNEL_END:   shadow_kend   = val & 32'h1F_FFFF;
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned kb, int unsigned kf, int unsigned ke);
        cfg_write(REG_MEMORY_KB, kb);
        cfg_write(REG_KERNEL_FIRST, kf);
        cfg_write(REG_KERNEL_END, ke);
    endtask

    // Hold until every request is sent and every result is back
    task automatic drain();
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0)
            @(negedge aclk);
    endtask

    task automatic push_req(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] a,
                            logic [COUNT_W-1:0] c);
        frame_req_t r;
        r.opcode = op;
        r.address = a;
        r.count = c;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [ADDR_W-1:0] pick_frame_address(int unsigned tot);
        int unsigned f;
        if ($urandom_range(0, 3) == 0) f = $urandom_range(0, tot + 3);
        else f = $urandom_range(RSV_LOW, (tot > RSV_LOW + 64) ? tot - 1 : RSV_LOW + 64);
        return ADDR_W'(f * FBYTES + $urandom_range(0, FBYTES - 1));
    endfunction

    // Mostly alloc/free traffic inside the managed area, some noise
    task automatic add_random(int n, int unsigned tot);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                push_req(OP_ALLOC_ONE, $urandom, COUNT_W'($urandom));
            else if (r < 50)
                push_req(OP_ALLOC_RUN, $urandom,
                         COUNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, tot + 2)
                                                              : $urandom_range(1, 16)));
            else if (r < 75)
                push_req(OP_FREE_ONE, pick_frame_address(tot), COUNT_W'($urandom));
            else if (r < 92)
                push_req(OP_FREE_RUN, pick_frame_address(tot),
                         COUNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 131072)
                                                              : $urandom_range(0, 32)));
            else if (r < 95)
                push_req(OP_INIT, $urandom, COUNT_W'($urandom));
            else if (r < 97)
                push_req(OPCODE_W'($urandom_range(5, 7)), $urandom, COUNT_W'($urandom));
            else
                push_req(($urandom_range(0, 1) != 0) ? OP_FREE_ONE : OP_FREE_RUN,
                         $urandom, COUNT_W'($urandom_range(0, 131071)));
        end
    endtask

    int unsigned kb, kf, ke, tot;
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Before any init: every allocation fails, frees do nothing
        push_req(OP_ALLOC_ONE, '0, '0);
        push_req(OP_ALLOC_RUN, '0, 18'd1);
        push_req(OP_FREE_ONE, 32'h0000_5000, '0);
        push_req(OP_FREE_RUN, '0, 18'd10);
        push_req(3'd7, 32'hFFFF_FFFF, 18'h3FFFF);
        push_req(OP_INIT, '0, '0);
        push_req(OP_ALLOC_ONE, '0, '0);
        drain();

        // Small memory with a kernel image inside it
        configure(4096, 300, 340);
        push_req(OP_INIT, '0, '0);
        push_req(OP_ALLOC_ONE, '0, '0);
        push_req(OP_ALLOC_RUN, '0, 18'd40);
        push_req(OP_ALLOC_RUN, '0, 18'd0);
        push_req(OP_ALLOC_RUN, '0, 18'd1025);
        push_req(OP_ALLOC_RUN, '0, 18'd684);
        push_req(OP_FREE_ONE, 32'h0000_0FFF, '0);
        push_req(OP_FREE_ONE, 32'h0000_0FFF, '0);
        push_req(OP_FREE_RUN, 32'h0000_0000, 18'd300);
        push_req(OP_FREE_RUN, 32'h0000_0000, 18'd0);
        push_req(OP_FREE_ONE, 32'hFFFF_FFFF, '0);
        push_req(OP_FREE_RUN, 32'h003F_F000, 18'd131072);
        push_req(OP_ALLOC_RUN, '0, 18'd1024);
        drain();

        // Reversed kernel range, then a single-frame memory
        configure(2048, 400, 100);
        push_req(OP_INIT, '0, '0);
        push_req(OP_ALLOC_RUN, '0, 18'd256);
        drain();
        configure(4, 1048575, 1048576);
        push_req(OP_INIT, '0, '0);
        push_req(OP_ALLOC_ONE, '0, '0);
        drain();

        // Full capacity, kernel running past the end
        configure(4194303, 131000, 1048576);
        push_req(OP_INIT, '0, '0);
        push_req(OP_ALLOC_ONE, '0, '0);
        push_req(OP_ALLOC_RUN, '0, 18'd100);
        push_req(OP_FREE_RUN, 32'h0010_0000, 18'd200);
        push_req(OP_ALLOC_RUN, '0, 18'd130000);
        drain();

        // Random phases over varied settings
        for (int p = 0; p < 12; p++) begin
            kb = $urandom_range(1024, 8192);
            if (p == 5) kb = 0;
            tot = kb / 4;
            kf = $urandom_range(0, tot + 50);
            ke = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1048576)
                                             : kf + $urandom_range(0, 80);
            configure(kb, kf, ke);
            push_req(OP_INIT, '0, '0);
            add_random(40, tot);
            // Let the block run dry before the rest of the phase
            drain();
            add_random(45, tot);
            drain();
        end

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_resps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
sv/bfa_pkg.sv
sv/bfa_ctrl.sv
sv/bfa_dpath.sv
sv/bitmap_frame_allocator_unit.sv
verif/tb_bitmap_frame_allocator_unit.sv
